>>> rtl/core/stl_pkg.sv
// ----------------------------------------------------------------------------
// stl_pkg
// Shared types, byte codes and classification helpers of the script token
// lexer.
// ----------------------------------------------------------------------------
package stl_pkg;

  localparam int unsigned PosW  = 32;
  localparam int unsigned OffW  = 32;
  localparam int unsigned DataW = 72;

  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_NL       = 8'h0A;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_QUOTE    = 8'h22;
  localparam logic [7:0] CH_HASH     = 8'h23;
  localparam logic [7:0] CH_DOLLAR   = 8'h24;
  localparam logic [7:0] CH_SEMI     = 8'h3B;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_RBRACKET = 8'h5D;
  localparam logic [7:0] CH_LBRACE   = 8'h7B;
  localparam logic [7:0] CH_RBRACE   = 8'h7D;

  typedef logic [PosW-1:0] pos_t;
  typedef logic [OffW-1:0] off_t;

  typedef enum logic [3:0] {
    KIND_WS,
    KIND_LIT,
    KIND_BRACE_L,
    KIND_BRACE_R,
    KIND_BRACKET_L,
    KIND_BRACKET_R,
    KIND_SUBST,
    KIND_QUOTE,
    KIND_SEMI,
    KIND_COMMENT
  } kind_e;

  typedef struct packed {
    kind_e kind;
    off_t  start;
    off_t  stop;
    logic  last;
    logic  done;
  } res_t;

  // Results of one byte handed from the core to the output stage
  typedef struct packed {
    logic       valid;
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } push_t;

  function automatic logic is_space(logic [7:0] b);
    return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
  endfunction

  function automatic logic word_byte(logic [7:0] b);
    return !is_space(b) && (b != CH_LBRACE) && (b != CH_RBRACE) &&
           (b != CH_LBRACKET) && (b != CH_RBRACKET) && (b != CH_SEMI);
  endfunction

endpackage

>>> rtl/core/stl_core.sv
// ----------------------------------------------------------------------------
// stl_core
// Input register, run state and token decision for one byte per cycle while the output stage is free.
// ----------------------------------------------------------------------------
module stl_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [7:0]    in_byte_i,
  input  logic          in_final_i,
  input  logic          out_free_i,
  output stl_pkg::push_t push_o
);
  import stl_pkg::*;

  localparam logic [2:0] MODE_IDLE    = 3'd0;
  localparam logic [2:0] MODE_WS      = 3'd1;
  localparam logic [2:0] MODE_LIT     = 3'd2;
  localparam logic [2:0] MODE_SUBST   = 3'd3;
  localparam logic [2:0] MODE_COMMENT = 3'd4;

  function automatic kind_e mode_kind(logic [2:0] m);
    kind_e k;
    unique case (m)
      MODE_WS:      k = KIND_WS;
      MODE_SUBST:   k = KIND_SUBST;
      MODE_COMMENT: k = KIND_COMMENT;
      default:      k = KIND_LIT;
    endcase
    return k;
  endfunction

  logic       vld_q;
  logic [7:0] byte_q;
  logic       fin_q;
  logic [2:0] mode_q, mode_d;
  pos_t       begin_q, begin_d;
  pos_t       pos_q, pos_d;

  logic       advance;
  logic       cont, close, single_hit, single_eff, opens, has_x;
  kind_e      single_kind;
  logic [2:0] mode_a, new_mode;
  pos_t       pn, new_begin;
  res_t       res_a, res_x;
  logic [1:0] cnt;

  assign advance    = vld_q && out_free_i;
  assign in_ready_o = !vld_q || out_free_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_ready_o) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q <= in_byte_i;
      fin_q  <= in_final_i;
    end
  end

  always_comb begin
    cont = 1'b0;
    unique case (mode_q)
      MODE_WS:               cont = is_space(byte_q);
      MODE_LIT, MODE_SUBST:  cont = word_byte(byte_q);
      MODE_COMMENT:          cont = (byte_q != CH_NL);
      default:               cont = 1'b0;
    endcase

    single_hit  = 1'b1;
    single_kind = KIND_LIT;
    unique case (byte_q)
      CH_LBRACE:   single_kind = KIND_BRACE_L;
      CH_RBRACE:   single_kind = KIND_BRACE_R;
      CH_LBRACKET: single_kind = KIND_BRACKET_L;
      CH_RBRACKET: single_kind = KIND_BRACKET_R;
      CH_SEMI:     single_kind = KIND_SEMI;
      CH_QUOTE:    single_kind = KIND_QUOTE;
      default:     single_hit  = 1'b0;
    endcase

    pn    = (&pos_q) ? pos_q : pos_q + PosW'(1);
    close = (mode_q != MODE_IDLE) && !cont;
    mode_a = close ? MODE_IDLE : mode_q;
    single_eff = (mode_a == MODE_IDLE) && single_hit;
    opens      = (mode_a == MODE_IDLE) && !single_hit;

    new_mode = mode_a;
    if (opens) begin
      if (is_space(byte_q)) begin
        new_mode = MODE_WS;
      end else if (byte_q == CH_DOLLAR) begin
        new_mode = MODE_SUBST;
      end else if (byte_q == CH_HASH) begin
        new_mode = MODE_COMMENT;
      end else begin
        new_mode = MODE_LIT;
      end
    end
    new_begin = opens ? pos_q : begin_q;

    has_x = single_eff || (fin_q && (new_mode != MODE_IDLE));
    cnt   = {1'b0, close} + {1'b0, has_x};

    res_a.kind  = mode_kind(mode_q);
    res_a.start = OffW'(begin_q);
    res_a.stop  = OffW'(pos_q);
    res_a.last  = (cnt == 2'd1);
    res_a.done  = fin_q && (cnt == 2'd1);

    res_x.kind  = single_eff ? single_kind : mode_kind(new_mode);
    res_x.start = single_eff ? OffW'(pos_q) : OffW'(new_begin);
    res_x.stop  = OffW'(pn);
    res_x.last  = 1'b1;
    res_x.done  = fin_q;

    push_o.valid = advance;
    push_o.cnt   = cnt;
    push_o.r0    = close ? res_a : res_x;
    push_o.r1    = res_x;

    if (fin_q) begin
      mode_d  = MODE_IDLE;
      begin_d = '0;
      pos_d   = '0;
    end else begin
      mode_d  = new_mode;
      begin_d = new_begin;
      pos_d   = pn;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      begin_q <= '0;
      pos_q   <= '0;
    end else if (advance) begin
      mode_q  <= mode_d;
      begin_q <= begin_d;
      pos_q   <= pos_d;
    end
  end

  a_final_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && fin_q) |=> (pos_q == '0) && (mode_q == MODE_IDLE))
    else $error("run state not cleared after final byte");

  a_mode_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q <= MODE_COMMENT))
    else $error("run mode out of range");

  a_pair_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && (cnt == 2'd2)) |-> close)
    else $error("two tokens without a closed run");

endmodule

>>> rtl/core/stl_out.sv
// ----------------------------------------------------------------------------
// stl_out
// Two-slot result register: takes up to two tokens per byte and hands them
// out one transaction at a time.
// ----------------------------------------------------------------------------
module stl_out (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  stl_pkg::push_t push_i,
  output logic          free_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output stl_pkg::res_t out_res_o
);
  import stl_pkg::*;

  logic [1:0] cnt_q, cnt_d;
  res_t       slot0_q, slot1_q;
  logic       pop;

  assign out_valid_o = (cnt_q != 2'd0);
  assign pop         = out_valid_o && out_ready_i;
  assign free_o      = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_ready_i);
  assign out_res_o   = slot0_q;

  always_comb begin
    cnt_d = cnt_q;
    if (push_i.valid) begin
      cnt_d = push_i.cnt;
    end else if (pop) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      slot0_q <= push_i.r0;
      slot1_q <= push_i.r1;
    end else if (pop) begin
      slot0_q <= slot1_q;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q <= 2'd2))
    else $error("result count overflow");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.valid |-> ((cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop)))
    else $error("results pushed over pending results");

  a_pair_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && (cnt_q == 2'd2)) |=> (cnt_q == 2'd1))
    else $error("second result lost");

  a_last_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd1) |-> slot0_q.last)
    else $error("final pending result not marked last");

endmodule

>>> rtl/core/script_token_lexer_top.sv
// ----------------------------------------------------------------------------
// script_token_lexer_top
// Script token lexer: one source byte in, zero to two tokens out.
// ----------------------------------------------------------------------------
// Input channel (s_axis): one byte per transaction in tdata[7:0]; tlast marks
// the last byte of the source text, which flushes any open run and restarts
// offsets at zero for the next source.
// Output channel (m_axis): one token per transaction. tdata carries kind,
// start offset and exclusive end offset; tuser is high on the last token
// caused by a byte; tlast is high on the final token of a source.
// A byte is held in the input register and its tokens are then registered
// in the two-slot result register, from which the first output transaction
// is offered.
// Throughput: one byte per cycle while each byte yields at most one token and
// the receiver takes each token; a byte that yields two tokens holds up the
// next byte while the single output channel drains the two-slot result register.
// Reset clears the run state, byte offset and both valid flags; no token is
// pending after reset. When the receiver stalls, the result register holds
// its tokens and s_axis_tready drops once the input register is also full.
// ----------------------------------------------------------------------------
module script_token_lexer_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [7:0]                s_axis_tdata,   // [7:0] byte_in
  input  logic                      s_axis_tlast,   // is_final
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [stl_pkg::DataW-1:0] m_axis_tdata,   // [3:0] token_kind,
                                                    // [35:4] token_start,
                                                    // [67:36] token_end,
                                                    // [71:68] zero
  output logic                      m_axis_tuser,   // last_of_run
  output logic                      m_axis_tlast    // stream_done
);
  import stl_pkg::*;

  push_t push;
  logic  free;
  res_t  res;

  stl_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_byte_i  (s_axis_tdata),
    .in_final_i (s_axis_tlast),
    .out_free_i (free),
    .push_o     (push)
  );

  stl_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .free_o      (free),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (res)
  );

  assign m_axis_tdata = {4'b0000, res.stop, res.start, res.kind};
  assign m_axis_tuser = res.last;
  assign m_axis_tlast = res.done;

endmodule
